// File: src/msl_pkg.sv
// shared types, constants and keyword tables for the modem status line parser
// no dependencies
package msl_pkg;

    localparam int LINE_CAP = 199;
    localparam int CNT_W    = $clog2(LINE_CAP + 1);

    localparam int NKW    = 9;
    localparam int KW_MAX = 11;
    localparam int KW_IW  = $clog2(NKW);
    localparam int KP_W   = $clog2(KW_MAX + 1);

    // item kinds
    localparam logic [3:0] KIND_RX        = 4'd0;
    localparam logic [3:0] KIND_SET_BUSY  = 4'd1;
    localparam logic [3:0] KIND_CLR_BUSY  = 4'd2;
    localparam logic [3:0] KIND_CLR_SEND  = 4'd3;
    localparam logic [3:0] KIND_CLR_JOIN  = 4'd4;
    localparam logic [3:0] KIND_CLR_ALL   = 4'd5;
    localparam logic [3:0] KIND_CLR_CRIT  = 4'd6;
    localparam logic [3:0] KIND_UART_ERR  = 4'd7;
    localparam logic [3:0] KIND_SET_CRIT  = 4'd8;

    // keyword indices, in priority-table order
    localparam int K_JFAIL    = 0;
    localparam int K_NETID    = 1;
    localparam int K_JOINED_U = 2;
    localparam int K_JOINED_L = 3;
    localparam int K_DONE     = 4;
    localparam int K_RECV     = 5;
    localparam int K_PLEASE   = 6;
    localparam int K_ERROR    = 7;
    localparam int K_BUSY     = 8;

    // status flag bit positions
    localparam int F_BUSY      = 0;
    localparam int F_JOIN_OK   = 1;
    localparam int F_JOIN_ERR  = 2;
    localparam int F_JOIN_DONE = 3;
    localparam int F_SENT_DONE = 4;
    localparam int F_SENT_ERR  = 5;
    localparam int F_ACK       = 6;
    localparam int F_CRIT      = 7;

    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_NUL  = 8'h00;

    // keyword text, left aligned and padded with blanks
    localparam logic [KW_MAX*8-1:0] KW_TEXT [NKW] = '{
        "Join failed",
        "NetID      ",
        "Joined     ",
        "joined     ",
        "Done       ",
        "Received   ",
        "Please join",
        "error      ",
        "busy       "
    };

    localparam logic [KP_W-1:0] KW_LEN [NKW] = '{
        KP_W'(11), KP_W'(5), KP_W'(6), KP_W'(6), KP_W'(4),
        KP_W'(8), KP_W'(11), KP_W'(5), KP_W'(4)
    };

    typedef struct packed {
        logic       match;
        logic       restart;
        logic [7:0] ch;
    } msl_step_t;

    typedef struct packed {
        logic line_end;
        logic eval_ok;
        logic plus_seen;
        logic prefix_join;
        logic prefix_cmsg;
    } msl_line_t;

    function automatic logic [7:0] kw_char(input logic [KW_IW-1:0] k, input int idx);
        logic [7:0] ch;
        ch = '0;
        if (idx >= 0 && idx < KW_MAX)
        begin
            ch = KW_TEXT[k][(KW_MAX-1-idx)*8 +: 8];
        end
        return ch;
    endfunction

    // longest keyword prefix that is a suffix of the matched part plus the new byte
    function automatic logic [KP_W-1:0] kw_advance(input logic [KW_IW-1:0] k,
                                                  input logic [KP_W-1:0] p,
                                                  input logic [7:0] c);
        logic [KP_W-1:0] res;
        logic            ok;
        int              j;
        res = '0;
        for (int q = 1; q <= KW_MAX; q++)
        begin
            ok = (q <= int'(KW_LEN[k])) && (q <= int'(p) + 1) && (kw_char(k, q - 1) == c);
            for (int i = 0; i < KW_MAX - 1; i++)
            begin
                j = int'(p) + 1 - q + i;
                if (i < q - 1 && kw_char(k, i) != kw_char(k, j))
                begin
                    ok = 1'b0;
                end
            end
            if (ok)
            begin
                res = KP_W'(q);
            end
        end
        return res;
    endfunction

endpackage

// File: src/modem_status_line_parser_core.sv
// top level of the modem status line parser: status flags, output skid stage
// depends on msl_pkg, msl_line_front and msl_kw_cell
//
// One item (received byte or status command) is taken per clock while item_stall is
// low, and each gives one result transfer holding line_end and the eight status flags
// after the update. The line framing and a row of nine keyword matcher cells all
// advance in the cycle the byte is taken; a skid register behind the output register
// keeps the input open for one more transfer while the output is stalled. item_stall
// rises only while both output registers are full. Lines of LINE_CAP bytes or more
// before the newline are dropped unparsed; parse_enable low discards closed lines.
module modem_status_line_parser_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [3:0] kind,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic       line_end,
    output logic       busy_res,
    output logic       join_ok,
    output logic       join_error,
    output logic       join_done,
    output logic       sent_done,
    output logic       sent_error,
    output logic       ack_received,
    output logic       critical_error,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       parse_enable
);
    import msl_pkg::*;

    logic               accept;
    msl_step_t          step [NKW+1];
    msl_line_t          line;
    logic [NKW-1:0]     kw_found;

    logic               parse_en_reg;
    logic [7:0]         flags_reg, flags_next;
    logic [8:0]         result;
    logic               out_valid_reg, out_valid_next;
    logic [8:0]         out_data_reg, out_data_next;
    logic               skid_valid_reg, skid_valid_next;
    logic [8:0]         skid_data_reg, skid_data_next;

    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    msl_line_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .kind    (kind),
        .rx_byte (rx_byte),
        .step    (step[0]),
        .line    (line)
    );

    for (genvar g = 0; g < NKW; g++)
    begin : g_cell
        msl_kw_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .kw_idx   (KW_IW'(g)),
            .step_in  (step[g]),
            .step_out (step[g+1]),
            .found    (kw_found[g])
        );
    end

    always_comb
    begin
        flags_next = flags_reg;
        if (accept)
        begin
            case (kind)
                KIND_RX:
                begin
                    if (line.eval_ok && parse_en_reg)
                    begin
                        if (line.plus_seen)
                        begin
                            flags_next[F_BUSY] = 1'b0;
                        end
                        if (line.prefix_join)
                        begin
                            if (kw_found[K_JFAIL])
                            begin
                                flags_next[F_JOIN_OK]  = 1'b0;
                                flags_next[F_JOIN_ERR] = 1'b1;
                            end
                            else if (kw_found[K_NETID] || kw_found[K_JOINED_U]
                                     || kw_found[K_JOINED_L])
                            begin
                                flags_next[F_JOIN_ERR] = 1'b0;
                                flags_next[F_JOIN_OK]  = 1'b1;
                            end
                            else if (kw_found[K_DONE])
                            begin
                                flags_next[F_JOIN_DONE] = 1'b1;
                            end
                        end
                        else if (line.prefix_cmsg)
                        begin
                            if (kw_found[K_DONE])
                            begin
                                flags_next[F_SENT_DONE] = 1'b1;
                            end
                            else if (kw_found[K_RECV])
                            begin
                                flags_next[F_ACK] = 1'b1;
                            end
                            else if (kw_found[K_PLEASE])
                            begin
                                flags_next[F_JOIN_OK]   = 1'b0;
                                flags_next[F_SENT_DONE] = 1'b0;
                                flags_next[F_JOIN_ERR]  = 1'b1;
                                flags_next[F_SENT_ERR]  = 1'b1;
                            end
                            else if (kw_found[K_ERROR] || kw_found[K_BUSY])
                            begin
                                flags_next[F_SENT_DONE] = 1'b0;
                                flags_next[F_SENT_ERR]  = 1'b1;
                            end
                        end
                    end
                end
                KIND_SET_BUSY: flags_next[F_BUSY] = 1'b1;
                KIND_CLR_BUSY: flags_next[F_BUSY] = 1'b0;
                KIND_CLR_SEND:
                begin
                    flags_next[F_SENT_ERR]  = 1'b0;
                    flags_next[F_SENT_DONE] = 1'b0;
                    flags_next[F_ACK]       = 1'b0;
                end
                KIND_CLR_JOIN:
                begin
                    flags_next[F_JOIN_OK]   = 1'b0;
                    flags_next[F_JOIN_ERR]  = 1'b0;
                    flags_next[F_JOIN_DONE] = 1'b0;
                end
                KIND_CLR_ALL:  flags_next = '0;
                KIND_CLR_CRIT: flags_next[F_CRIT] = 1'b0;
                KIND_UART_ERR: flags_next[F_CRIT] = 1'b1;
                KIND_SET_CRIT: flags_next[F_CRIT] = 1'b1;
                default:       flags_next = flags_reg;
            endcase
        end
    end

    assign result = {flags_next, line.line_end};

    // output register with one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || !res_stall)
        begin
            out_valid_next  = skid_valid_reg || accept;
            out_data_next   = skid_valid_reg ? skid_data_reg : result;
            skid_valid_next = 1'b0;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_en_reg   <= 1'b1;
            flags_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                parse_en_reg <= parse_enable;
            end
            flags_reg      <= flags_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign res_valid      = out_valid_reg;
    assign line_end       = out_data_reg[0];
    assign busy_res       = out_data_reg[1 + F_BUSY];
    assign join_ok        = out_data_reg[1 + F_JOIN_OK];
    assign join_error     = out_data_reg[1 + F_JOIN_ERR];
    assign join_done      = out_data_reg[1 + F_JOIN_DONE];
    assign sent_done      = out_data_reg[1 + F_SENT_DONE];
    assign sent_error     = out_data_reg[1 + F_SENT_ERR];
    assign ack_received   = out_data_reg[1 + F_ACK];
    assign critical_error = out_data_reg[1 + F_CRIT];

    // skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without output entry");

    // a closed line leaves every keyword cell cleared
    a_line_clears_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_RX && rx_byte == CH_NL) |=> (kw_found == '0))
        else $error("keyword cells not cleared at end of line");

    // uart error raises the critical flag
    a_uart_err_crit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_UART_ERR) |=> flags_reg[F_CRIT])
        else $error("critical flag not set after uart error");

endmodule

// File: src/msl_kw_cell.sv
// one keyword matcher cell: partial-match progress and a sticky found bit
// depends on msl_pkg
module msl_kw_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [msl_pkg::KW_IW-1:0]     kw_idx,
    input  msl_pkg::msl_step_t            step_in,
    output msl_pkg::msl_step_t            step_out,
    output logic                          found
);
    import msl_pkg::*;

    logic [KP_W-1:0] prog_reg, prog_next;
    logic            found_reg, found_next;
    logic [KP_W-1:0] adv;

    assign adv = kw_advance(kw_idx, prog_reg, step_in.ch);

    always_comb
    begin
        prog_next  = prog_reg;
        found_next = found_reg;
        if (step_in.restart)
        begin
            prog_next  = '0;
            found_next = 1'b0;
        end
        else if (step_in.match && !found_reg)
        begin
            if (adv >= KW_LEN[kw_idx])
            begin
                found_next = 1'b1;
                prog_next  = '0;
            end
            else
            begin
                prog_next = adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prog_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            prog_reg  <= prog_next;
            found_reg <= found_next;
        end
    end

    // byte and strobes travel on to the neighbour cell
    assign step_out = step_in;
    assign found    = found_reg;

endmodule

// File: src/msl_line_front.sv
// line framing: byte count, overflow, plus and zero detection, prefix matcher
// depends on msl_pkg
module msl_line_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [3:0]          kind,
    input  logic [7:0]          rx_byte,
    output msl_pkg::msl_step_t  step,
    output msl_pkg::msl_line_t  line
);
    import msl_pkg::*;

    localparam logic [2:0] PFX_IDLE = 3'd0;
    localparam logic [2:0] PFX_DONE = 3'd6;
    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_JOIN = 2'd1;
    localparam logic [1:0] CLS_CMSG = 2'd2;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             plus_reg, plus_next;
    logic             zero_reg, zero_next;
    logic [2:0]       pfx_reg, pfx_next;
    logic [1:0]       cls_reg, cls_next;

    logic rx, is_nl, in_cap, matching, restart;
    logic [7:0] pfx_ch;

    assign rx       = accept && (kind == KIND_RX);
    assign is_nl    = (rx_byte == CH_NL);
    assign in_cap   = (count_reg < CNT_W'(LINE_CAP));
    assign matching = in_cap && !zero_reg;
    assign restart  = (rx && is_nl) || (accept && (kind == KIND_UART_ERR));

    // expected byte at the current prefix position
    always_comb
    begin
        case (pfx_reg)
            3'd2:    pfx_ch = (cls_reg == CLS_JOIN) ? "O" : "M";
            3'd3:    pfx_ch = (cls_reg == CLS_JOIN) ? "I" : "S";
            3'd4:    pfx_ch = (cls_reg == CLS_JOIN) ? "N" : "G";
            default: pfx_ch = CH_NUL;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        plus_next  = plus_reg;
        zero_next  = zero_reg;
        pfx_next   = pfx_reg;
        cls_next   = cls_reg;
        if (rx)
        begin
            if (in_cap)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (matching)
            begin
                if (rx_byte == CH_NUL)
                begin
                    zero_next = 1'b1;
                    if (pfx_reg != PFX_DONE)
                    begin
                        pfx_next = PFX_DONE;
                        cls_next = CLS_NONE;
                    end
                end
                else
                begin
                    if (rx_byte == CH_PLUS)
                    begin
                        plus_next = 1'b1;
                    end
                    if (pfx_reg == PFX_IDLE)
                    begin
                        if (rx_byte == CH_PLUS)
                        begin
                            pfx_next = 3'd1;
                            cls_next = CLS_NONE;
                        end
                        else if (rx_byte != CH_CR && rx_byte != CH_NL && rx_byte != CH_SP)
                        begin
                            pfx_next = PFX_DONE;
                            cls_next = CLS_NONE;
                        end
                    end
                    else if (pfx_reg == 3'd1)
                    begin
                        if (rx_byte == "J")
                        begin
                            pfx_next = 3'd2;
                            cls_next = CLS_JOIN;
                        end
                        else if (rx_byte == "C")
                        begin
                            pfx_next = 3'd2;
                            cls_next = CLS_CMSG;
                        end
                        else
                        begin
                            pfx_next = PFX_DONE;
                            cls_next = CLS_NONE;
                        end
                    end
                    else if (pfx_reg != PFX_DONE)
                    begin
                        if (cls_reg != CLS_NONE && rx_byte == pfx_ch)
                        begin
                            pfx_next = (pfx_reg == 3'd4) ? PFX_DONE : pfx_reg + 3'd1;
                        end
                        else
                        begin
                            pfx_next = PFX_DONE;
                            cls_next = CLS_NONE;
                        end
                    end
                end
            end
            if (is_nl)
            begin
                ovf_next = 1'b0;
            end
        end
        if (restart)
        begin
            count_next = '0;
            plus_next  = 1'b0;
            zero_next  = 1'b0;
            pfx_next   = PFX_IDLE;
            cls_next   = CLS_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            plus_reg  <= 1'b0;
            zero_reg  <= 1'b0;
            pfx_reg   <= PFX_IDLE;
            cls_reg   <= CLS_NONE;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            plus_reg  <= plus_next;
            zero_reg  <= zero_next;
            pfx_reg   <= pfx_next;
            cls_reg   <= cls_next;
        end
    end

    assign step.match   = rx && matching && (rx_byte != CH_NUL);
    assign step.restart = restart;
    assign step.ch      = rx_byte;

    // a newline never completes a keyword or a prefix, so the held state decides
    assign line.line_end    = rx && is_nl;
    assign line.eval_ok     = rx && is_nl && in_cap && !ovf_reg;
    assign line.plus_seen   = plus_reg;
    assign line.prefix_join = (pfx_reg == PFX_DONE) && (cls_reg == CLS_JOIN);
    assign line.prefix_cmsg = (pfx_reg == PFX_DONE) && (cls_reg == CLS_CMSG);

endmodule
